// ===== rtl/rc_frame_channel_unpacker_top_defines.svh =====
// ----------------------------------------------------------------------------
// rc_frame_channel_unpacker_top_defines
// Assertion macros used by the unpacker parser.
// ----------------------------------------------------------------------------
`ifndef RC_FRAME_CHANNEL_UNPACKER_TOP_DEFINES_SVH
`define RC_FRAME_CHANNEL_UNPACKER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RCFU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcfu: assertion failed");

// Next-cycle implication, checked out of reset.
`define RCFU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcfu: assertion failed");

`endif

// ===== rtl/rcfu_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfu_pkg
// Types and constants of the RC frame channel unpacker.
// ----------------------------------------------------------------------------
package rcfu_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CHANNEL_BITS = 11;

  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 4;
  localparam int VALUE_W  = 11;
  localparam int STORE_W  = CHANNEL_BITS + BYTE_W - 1;
  localparam int HELD_W   = $clog2(STORE_W + 1);
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - IDX_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hC8;
  localparam logic [BYTE_W-1:0] TYPE_RESET = 8'h16;

  // Register index, taken from the word address bit.
  localparam logic REG_SYNC = 1'b0;
  localparam logic REG_TYPE = 1'b1;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_LEN     = 3'd1,
    ST_TYPE    = 3'd2,
    ST_PAYLOAD = 3'd3,
    ST_CRC     = 3'd4
  } stage_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_value;
    logic [BYTE_W-1:0] type_value;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   channel_index;
    logic [VALUE_W-1:0] channel_value;
    logic               last_channel;
  } result_t;

endpackage

// ===== rtl/rc_frame_channel_unpacker_top.sv =====
// ----------------------------------------------------------------------------
// rc_frame_channel_unpacker_top
// Byte-stream unpacker for packed RC channel frames: one received byte per
// item in, one 11-bit channel with its index per result item out.
// ----------------------------------------------------------------------------
// A channel is registered and appears on out_* in the cycle after the byte that completes it.
// One byte per cycle while in_tready is high; the parser state updates with each accepted byte.
// The result register lets a new byte in while the sink takes the old result.
// Reset (rst_n low, synchronous): hunting for sync, bit store and channel count
// cleared, no result pending, sync byte 0xC8 and frame type 0x16.
module rc_frame_channel_unpacker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rcfu_pkg::OUT_TDATA_W-1:0] out_tdata,  // [3:0] channel_index,
                                                       // [14:4] channel_value, [15] 0
  output logic                             out_tlast,  // last_channel
  // Configuration.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [rcfu_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [rcfu_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [rcfu_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import rcfu_pkg::*;

  cfg_t               cfg;
  result_t            res;
  logic               in_fire;
  logic [IDX_W-1:0]   out_index;
  logic [VALUE_W-1:0] out_value;

  assign in_fire = in_tvalid & in_tready;

  rcfu_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rcfu_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .rx_byte (in_tdata),
    .cfg     (cfg),
    .res     (res)
  );

  rcfu_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_index (out_index),
    .out_value (out_value),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_value, out_index};

endmodule

// ===== rtl/rcfu_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rcfu_cfg_regs
// APB register file holding the sync byte and the frame type byte.
// ----------------------------------------------------------------------------
module rcfu_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [rcfu_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [rcfu_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [rcfu_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output rcfu_pkg::cfg_t                   cfg
);
  import rcfu_pkg::*;

  logic [BYTE_W-1:0] sync_r, sync_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic              wr_en;
  logic              reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1];

  always_comb begin
    sync_nxt = sync_r;
    type_nxt = type_r;
    if (wr_en) begin
      case (reg_sel)
        REG_SYNC: sync_nxt = cfg_pwdata[BYTE_W-1:0];
        REG_TYPE: type_nxt = cfg_pwdata[BYTE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
      type_r <= TYPE_RESET;
    end else begin
      sync_r <= sync_nxt;
      type_r <= type_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SYNC: cfg_prdata = CFG_DATA_W'(sync_r);
      REG_TYPE: cfg_prdata = CFG_DATA_W'(type_r);
      default:  cfg_prdata = '0;
    endcase
  end

  assign cfg.sync_value = sync_r;
  assign cfg.type_value = type_r;

endmodule

// ===== rtl/rcfu_parser.sv =====
// ----------------------------------------------------------------------------
// rcfu_parser
// Frame state machine and bit gatherer; produces at most one channel per byte.
// ----------------------------------------------------------------------------
`include "rc_frame_channel_unpacker_top_defines.svh"

module rcfu_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic [rcfu_pkg::BYTE_W-1:0]  rx_byte,
  input  rcfu_pkg::cfg_t               cfg,
  output rcfu_pkg::result_t            res
);
  import rcfu_pkg::*;

  stage_t             stage_r, stage_nxt;
  logic [STORE_W-1:0] store_r, store_nxt;
  logic [HELD_W-1:0]  held_r, held_nxt;
  logic [IDX_W-1:0]   next_ch_r, next_ch_nxt;

  logic [STORE_W-1:0] merged;
  logic [STORE_W-1:0] store_shift;
  logic [HELD_W-1:0]  held_sum;
  logic [HELD_W-1:0]  held_left;
  logic               ch_done;
  logic               is_last;
  logic               sync_hit;
  logic               type_hit;

  // Payload bytes go in little-endian above the bits already held.
  assign merged      = store_r | (STORE_W'(rx_byte) << held_r);
  assign held_sum    = held_r + HELD_W'(BYTE_W);
  assign ch_done     = held_sum >= HELD_W'(CHANNEL_BITS);
  assign held_left   = held_sum - HELD_W'(CHANNEL_BITS);
  assign store_shift = merged >> CHANNEL_BITS;
  assign is_last     = next_ch_r == IDX_W'(NUM_CHANNELS - 1);
  assign sync_hit    = rx_byte == cfg.sync_value;
  assign type_hit    = rx_byte == cfg.type_value;

  always_comb begin
    stage_nxt = stage_r;
    if (in_fire) begin
      case (stage_r)
        ST_HUNT:    if (sync_hit) stage_nxt = ST_LEN;
        ST_LEN:     stage_nxt = ST_TYPE;
        ST_TYPE:    stage_nxt = type_hit ? ST_PAYLOAD : ST_HUNT;
        ST_PAYLOAD: if (ch_done && is_last) stage_nxt = ST_CRC;
        default:    stage_nxt = ST_HUNT;
      endcase
    end
  end

  always_comb begin
    store_nxt   = store_r;
    held_nxt    = held_r;
    next_ch_nxt = next_ch_r;
    res         = '0;
    res.channel_index = next_ch_r;
    res.channel_value = VALUE_W'(merged[CHANNEL_BITS-1:0]);
    res.last_channel  = is_last;
    if (in_fire) begin
      case (stage_r)
        ST_HUNT: begin
          if (sync_hit) begin
            store_nxt   = '0;
            held_nxt    = '0;
            next_ch_nxt = '0;
          end
        end
        ST_LEN: ;
        ST_TYPE: begin
          if (type_hit) begin
            store_nxt   = '0;
            held_nxt    = '0;
            next_ch_nxt = '0;
          end
        end
        ST_PAYLOAD: begin
          store_nxt = merged;
          held_nxt  = held_sum;
          if (ch_done) begin
            res.valid = 1'b1;
            store_nxt = store_shift;
            held_nxt  = held_left;
            // With narrow channels a second complete channel is dropped.
            if (held_left >= HELD_W'(CHANNEL_BITS)) begin
              store_nxt = '0;
              held_nxt  = '0;
            end
            next_ch_nxt = is_last ? '0 : next_ch_r + IDX_W'(1);
          end
        end
        default: begin
          store_nxt   = '0;
          held_nxt    = '0;
          next_ch_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= ST_HUNT;
      store_r   <= '0;
      held_r    <= '0;
      next_ch_r <= '0;
    end else begin
      stage_r   <= stage_nxt;
      store_r   <= store_nxt;
      held_r    <= held_nxt;
      next_ch_r <= next_ch_nxt;
    end
  end

  `RCFU_ASSERT_NOW(a_held_below_channel, 1'b1, held_r < HELD_W'(CHANNEL_BITS))
  `RCFU_ASSERT_NOW(a_index_in_range, 1'b1, next_ch_r <= IDX_W'(NUM_CHANNELS - 1))
  `RCFU_ASSERT_NOW(a_result_in_payload, res.valid, stage_r == ST_PAYLOAD && in_fire)
  `RCFU_ASSERT_NEXT(a_last_goes_crc, res.valid && res.last_channel, stage_r == ST_CRC)

endmodule

// ===== rtl/rcfu_out_reg.sv =====
// ----------------------------------------------------------------------------
// rcfu_out_reg
// Result register on the output stream; frees itself as the sink takes an item.
// ----------------------------------------------------------------------------
module rcfu_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rcfu_pkg::result_t             res,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcfu_pkg::IDX_W-1:0]    out_index,
  output logic [rcfu_pkg::VALUE_W-1:0]  out_value,
  output logic                          out_last
);
  import rcfu_pkg::*;

  logic               valid_r, valid_nxt;
  logic [IDX_W-1:0]   index_r;
  logic [VALUE_W-1:0] value_r;
  logic               last_r;

  // A new byte may enter whenever the held result is gone or leaves now.
  assign in_ready = !valid_r || out_ready;

  always_comb begin
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      index_r <= res.channel_index;
      value_r <= res.channel_value;
      last_r  <= res.last_channel;
    end
  end

  assign out_valid = valid_r;
  assign out_index = index_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule
